### design/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and constants of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int POS_W    = 6;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_INS_AT   = 3'd2,
        CMD_REM_HEAD = 3'd3,
        CMD_REM_TAIL = 3'd4,
        CMD_REM_AT   = 3'd5,
        CMD_DUMP     = 3'd6
    } t_cmd;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_FULL   = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } t_ple_state;

    // what every cell of the chain does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    // control broadcast to the cell chain
    typedef struct packed {
        t_cell_op           op;
        logic [POS_W-1:0]   target;   // position of insert or removal
        logic [POS_W-1:0]   tail;     // last occupied position, for rotation
    } t_cell_ctrl;

endpackage

### design/ple_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell
// one slot of the list chain: holds a handle and shifts with its neighbours
// ----------------------------------------------------------------------------
module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  t_cell_ctrl          i_ctrl,
    input  logic [HANDLE_W-1:0] i_elem,     // handle being inserted
    input  logic [HANDLE_W-1:0] i_left,     // slot of position IDX-1
    input  logic [HANDLE_W-1:0] i_right,    // slot of position IDX+1
    input  logic [HANDLE_W-1:0] i_first,    // slot of position 0
    output logic [HANDLE_W-1:0] o_slot
);

    localparam logic [POS_W-1:0] L_IDX = POS_W'(IDX);

    logic [HANDLE_W-1:0] r_slot;
    logic [HANDLE_W-1:0] n_slot;

    // next slot value from the broadcast operation
    always_comb begin
        n_slot = r_slot;
        unique case (i_ctrl.op)
            CELL_INSERT: begin
                if (L_IDX > i_ctrl.target) begin
                    n_slot = i_left;
                end else if (L_IDX == i_ctrl.target) begin
                    n_slot = i_elem;
                end
            end
            CELL_REMOVE: begin
                if (L_IDX >= i_ctrl.target) begin
                    n_slot = i_right;
                end
            end
            CELL_ROTATE: begin
                n_slot = (L_IDX == i_ctrl.tail) ? i_first : i_right;
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    // slot register, payload only
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

### design/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of element handles with positional insert, remove and dump
// ----------------------------------------------------------------------------
// Commands arrive on the slave stream: one transaction carries command,
// position and element. Results leave on the master stream: tdata carries the
// handle and entry index, tuser the status, tlast marks the final result of a
// command. The list sits in a chain of CAPACITY cells; an insert shifts the
// cells above the target up by one, a removal shifts them down, both in the
// cycle the command is accepted, and the single result of every non-dump
// command is in the output register on the next cycle.
// A dump is accepted, then rotates the chain one place per cycle while the
// output register is free and emits the head cell each time; after the last
// entry the chain is back in its original order.
// No command is accepted while a dump runs.
// The output register is reloaded in the cycle its result is taken, so a
// stalled receiver only holds the engine while the register is occupied.
// Reset empties the list (count to zero) and clears the output valid; slot
// contents are not cleared, as slots above the count are never read.
// ----------------------------------------------------------------------------
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // command[2:0], position[8:3], element[40:9]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // handle_out[31:0], entry_index[37:32]
    output logic [1:0]  o_m_tuser,   // status[1:0]
    output logic        o_m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int CMP_W = 7;

    // command fields
    logic [CMD_W-1:0]    w_cmd;
    logic [POS_W-1:0]    w_pos;
    logic [HANDLE_W-1:0] w_elem;

    assign w_cmd  = i_s_tdata[2:0];
    assign w_pos  = i_s_tdata[8:3];
    assign w_elem = i_s_tdata[40:9];

    // control state
    t_ple_state      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_dump_idx, n_dump_idx;

    // output register
    logic                r_m_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [INDEX_W-1:0]  r_index, n_index;
    logic                r_last, n_last;
    logic                n_emit;

    logic                w_out_free;
    logic                w_accept;
    t_cell_ctrl          w_ctrl;
    logic [HANDLE_W-1:0] w_slot [CAPACITY];
    logic [HANDLE_W-1:0] w_picked;
    logic [POS_W-1:0]    w_count_m1;
    logic                w_full;

    assign w_out_free = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_count_m1 = POS_W'(r_count - CW'(1));
    assign w_full     = (r_count == CW'(CAPACITY));

    // chain of slot cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ple_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_elem  (w_elem),
            .i_left  (w_slot[(g == 0) ? 0 : g - 1]),
            .i_right (w_slot[(g == CAPACITY - 1) ? g : g + 1]),
            .i_first (w_slot[0]),
            .o_slot  (w_slot[g])
        );
    end

    // handle at the removal target
    always_comb begin
        w_picked = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (POS_W'(k) == w_ctrl.target) begin
                w_picked = w_picked | w_slot[k];
            end
        end
    end

    // sequencer: command decode, dump walk and result formation
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dump_idx  = r_dump_idx;
        n_emit      = 1'b0;
        n_status    = STAT_OK;
        n_handle    = '0;
        n_index     = '0;
        n_last      = 1'b1;
        w_ctrl.op     = CELL_HOLD;
        w_ctrl.target = '0;
        w_ctrl.tail   = w_count_m1;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_emit = 1'b1;
                    unique case (w_cmd)
                        CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
                            if (w_cmd == CMD_INS_HEAD) begin
                                w_ctrl.target = '0;
                            end else if (w_cmd == CMD_INS_TAIL) begin
                                w_ctrl.target = POS_W'(r_count);
                            end else begin
                                w_ctrl.target = w_pos;
                            end
                            priority if (w_cmd == CMD_INS_AT
                                         && CMP_W'(w_pos) > CMP_W'(r_count)) begin
                                n_status = STAT_BADPOS;
                            end else if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_ctrl.op = CELL_INSERT;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_AT: begin
                            if (w_cmd == CMD_REM_HEAD) begin
                                w_ctrl.target = '0;
                            end else if (w_cmd == CMD_REM_TAIL) begin
                                w_ctrl.target = w_count_m1;
                            end else begin
                                w_ctrl.target = w_pos;
                            end
                            priority if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else if (w_cmd == CMD_REM_AT
                                         && CMP_W'(w_pos) >= CMP_W'(r_count)) begin
                                n_status = STAT_BADPOS;
                            end else begin
                                w_ctrl.op = CELL_REMOVE;
                                n_handle  = w_picked;
                                n_count   = r_count - CW'(1);
                            end
                        end
                        CMD_DUMP: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_emit     = 1'b0;
                                n_state    = ST_DUMP;
                                n_dump_idx = '0;
                            end
                        end
                        default: begin
                            n_status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (w_out_free) begin
                    n_emit     = 1'b1;
                    n_handle   = w_slot[0];
                    n_index    = INDEX_W'(r_dump_idx);
                    n_last     = (POS_W'(r_dump_idx) == w_count_m1);
                    w_ctrl.op  = CELL_ROTATE;
                    n_dump_idx = r_dump_idx + IW'(1);
                    if (n_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_dump_idx <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_dump_idx <= n_dump_idx;
            if (n_emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            r_status <= n_status;
            r_handle <= n_handle;
            r_index  <= n_index;
            r_last   <= n_last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00, r_index, r_handle};
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;

    // the count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // the final dump result returns the sequencer to idle
    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP && n_emit && n_last) |=> (r_state == ST_IDLE))
        else $error("dump did not end after its last entry");

    // a dump never changes the count
    a_dump_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |=> (r_count == $past(r_count)))
        else $error("count changed during dump");

endmodule
